// ----- hdl/orlb_pkg.sv -----
// ----------------------------------------------------------------------------
// orlb_pkg: shared definitions for the overwrite ring log buffer
// Field widths, result status codes, opcodes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package orlb_pkg;

	// Default sizing handed to the top level parameters.
	localparam int DEF_MAX_RING_BYTES = 16384;
	localparam int DEF_MAX_READ_BURST = 16;

	// Fixed field widths.
	localparam int DATA_W    = 8;
	localparam int OFF_W     = 48;
	localparam int LEN_W     = 5;
	localparam int SIZE_W    = 5;
	localparam int STATUS_W  = 2;
	localparam int KIB_SHIFT = 10;

	// Input opcodes.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DATA    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NODATA  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STORED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cfg_wr;
		logic latch_in;
		logic do_append;
		logic calc_dist;
		logic calc_check;
		logic rd_issue;
		logic emit_nodata;
		logic emit_byte;
	} orlb_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic rd_empty;
		logic rd_last;
	} orlb_sts_t;

endpackage

// ----- hdl/orlb_ctrl.sv -----
// ----------------------------------------------------------------------------
// orlb_ctrl: sequencing state machine for the overwrite ring log buffer
// Steps each accepted transaction through the datapath and owns the valid
// flag of the result register.
// ----------------------------------------------------------------------------
module orlb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  orlb_pkg::orlb_sts_t  sts,
	output orlb_pkg::orlb_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_DIST,
		S_CHECK,
		S_NODATA,
		S_ISSUE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   load_out;

	// The result register can take a new result when it is empty or draining.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.cfg_wr   = cfg_valid && (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = (opcode == orlb_pkg::OP_READ) ? S_DIST : S_APPEND;
				end
			end
			S_APPEND: begin
				if (slot_free) begin
					cmd.do_append = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_DIST: begin
				cmd.calc_dist = 1'b1;
				state_d       = S_CHECK;
			end
			S_CHECK: begin
				cmd.calc_check = 1'b1;
				state_d        = sts.rd_empty ? S_NODATA : S_ISSUE;
			end
			S_NODATA: begin
				if (slot_free) begin
					cmd.emit_nodata = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_ISSUE: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit_byte = 1'b1;
					state_d       = sts.rd_last ? S_IDLE : S_ISSUE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign load_out = cmd.do_append || cmd.emit_nodata || cmd.emit_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/orlb_dp.sv -----
// ----------------------------------------------------------------------------
// orlb_dp: datapath of the overwrite ring log buffer
// Byte store, ring pointers, offset bookkeeping, read burst address
// generation and the result register.
// ----------------------------------------------------------------------------
module orlb_dp #(
	parameter int MAX_RING_BYTES = orlb_pkg::DEF_MAX_RING_BYTES,
	parameter int MAX_READ_BURST = orlb_pkg::DEF_MAX_READ_BURST,
	localparam int PTR_W = $clog2(MAX_RING_BYTES),
	localparam int SZ_W  = $clog2(MAX_RING_BYTES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  orlb_pkg::orlb_cmd_t                 cmd,
	output orlb_pkg::orlb_sts_t                 sts,
	input  logic [orlb_pkg::SIZE_W-1:0]         size_kib,
	input  logic [orlb_pkg::DATA_W-1:0]         data_byte,
	input  logic                                end_of_message,
	input  logic [orlb_pkg::OFF_W-1:0]          read_offset,
	input  logic [orlb_pkg::LEN_W-1:0]          read_length,
	output logic [orlb_pkg::DATA_W-1:0]         read_byte,
	output logic [orlb_pkg::OFF_W-1:0]          byte_offset,
	output logic [orlb_pkg::STATUS_W-1:0]       status,
	output logic                                last,
	output logic [PTR_W-1:0]                    fill_level,
	output logic [orlb_pkg::OFF_W-1:0]          end_offset
);

	localparam int OFF_W  = orlb_pkg::OFF_W;
	localparam int DATA_W = orlb_pkg::DATA_W;
	localparam int LEN_W  = orlb_pkg::LEN_W;
	localparam logic [SZ_W-1:0] RESET_SIZE =
		SZ_W'((1 << orlb_pkg::KIB_SHIFT) > MAX_RING_BYTES ?
			MAX_RING_BYTES : (1 << orlb_pkg::KIB_SHIFT));

	// Byte store; contents are undefined until written.
	logic [DATA_W-1:0] mem [MAX_RING_BYTES];
	logic [DATA_W-1:0] rdata_q;

	// Latched input item.
	logic [DATA_W-1:0] data_q;
	logic              eom_q;
	logic [OFF_W-1:0]  roff_q;
	logic [LEN_W-1:0]  rlen_q;

	// Ring state.
	logic [SZ_W-1:0]   size_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [PTR_W-1:0]  fill_q;
	logic [PTR_W-1:0]  mcnt_q;
	logic [OFF_W-1:0]  oldest_q;
	logic [OFF_W-1:0]  tw_q;

	// Read burst state.
	logic [OFF_W-1:0]  dist_q;
	logic [PTR_W-1:0]  pos_q;
	logic [OFF_W-1:0]  boff_q;
	logic [LEN_W-1:0]  blen_q;
	logic [LEN_W-1:0]  bcnt_q;

	// Result register.
	logic [DATA_W-1:0]             res_byte_q;
	logic [OFF_W-1:0]              res_off_q;
	logic [orlb_pkg::STATUS_W-1:0] res_status_q;
	logic                          res_last_q;
	logic [PTR_W-1:0]              res_fill_q;
	logic [OFF_W-1:0]              res_tw_q;

	// Size decode for a configuration write.
	localparam int SIZE_W_LOCAL = orlb_pkg::SIZE_W;
	logic [SIZE_W_LOCAL-1:0] size_eff;
	logic [31:0]       size_prod;
	logic [SZ_W-1:0]   size_next;

	// Append arithmetic.
	logic [SZ_W-1:0]   size_m1;
	logic              drop_c;
	logic [SZ_W-1:0]   fill_p1;
	logic              ovr_c;
	logic              at_full;
	logic [SZ_W-1:0]   wp_inc;
	logic [PTR_W-1:0]  wp_n;
	logic [SZ_W-1:0]   wp_n_inc;
	logic [PTR_W-1:0]  rp_ovr;
	logic [PTR_W-1:0]  fill_n;
	logic [OFF_W-1:0]  tw_n;

	// Read setup arithmetic.
	logic [OFF_W-1:0]  diff_c;
	logic [LEN_W-1:0]  len_cap;
	logic [PTR_W-1:0]  avail_c;
	logic [LEN_W-1:0]  len_eff;
	logic [SZ_W:0]     pos_sum;
	logic [PTR_W-1:0]  pos_c;
	logic [SZ_W-1:0]   pos_inc;
	logic [PTR_W-1:0]  pos_n;

	assign size_eff  = (size_kib == '0) ? SIZE_W_LOCAL'(1) : size_kib;
	assign size_prod = 32'(size_eff) << orlb_pkg::KIB_SHIFT;
	assign size_next = (size_prod > 32'(MAX_RING_BYTES)) ? SZ_W'(MAX_RING_BYTES)
	                                                      : SZ_W'(size_prod);

	assign size_m1  = size_q - SZ_W'(1);
	assign drop_c   = SZ_W'(mcnt_q) >= size_m1;
	assign fill_p1  = SZ_W'(fill_q) + SZ_W'(1);
	assign ovr_c    = fill_p1 >= size_m1;
	assign at_full  = SZ_W'(fill_q) == size_m1;
	assign wp_inc   = SZ_W'(wp_q) + SZ_W'(1);
	assign wp_n     = (wp_inc == size_q) ? '0 : PTR_W'(wp_inc);
	assign wp_n_inc = SZ_W'(wp_n) + SZ_W'(1);
	assign rp_ovr   = (wp_n_inc == size_q) ? '0 : PTR_W'(wp_n_inc);
	assign fill_n   = ovr_c ? PTR_W'(size_m1) : PTR_W'(fill_p1);
	assign tw_n     = tw_q + OFF_W'(1);

	// A distance in the upper half of the offset space means below the oldest byte.
	assign diff_c  = roff_q - oldest_q;
	assign len_cap = (32'(rlen_q) > 32'(MAX_READ_BURST)) ? LEN_W'(MAX_READ_BURST) : rlen_q;
	assign avail_c = fill_q - dist_q[PTR_W-1:0];
	assign len_eff = (avail_c < PTR_W'(len_cap)) ? LEN_W'(avail_c) : len_cap;
	assign pos_sum = (SZ_W+1)'(rp_q) + (SZ_W+1)'(dist_q[PTR_W-1:0]);
	assign pos_c   = (pos_sum >= (SZ_W+1)'(size_q)) ? PTR_W'(pos_sum - (SZ_W+1)'(size_q))
	                                                : PTR_W'(pos_sum);
	assign pos_inc = SZ_W'(pos_q) + SZ_W'(1);
	assign pos_n   = (pos_inc == size_q) ? '0 : PTR_W'(pos_inc);

	assign sts.rd_empty = (|dist_q[OFF_W-1:PTR_W]) || (dist_q[PTR_W-1:0] >= fill_q)
	                      || (rlen_q == '0);
	assign sts.rd_last  = (bcnt_q == blen_q - LEN_W'(1));

	// Store port: one write and one registered read.
	always_ff @(posedge clk) begin
		if (cmd.do_append && !drop_c) begin
			mem[wp_q] <= data_q;
		end
		if (cmd.rd_issue) begin
			rdata_q <= mem[pos_q];
		end
	end

	// Ring state, cleared by reset and by a size write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= RESET_SIZE;
			wp_q     <= '0;
			rp_q     <= '0;
			fill_q   <= '0;
			mcnt_q   <= '0;
			oldest_q <= '0;
			tw_q     <= '0;
		end else if (cmd.cfg_wr) begin
			size_q   <= size_next;
			wp_q     <= '0;
			rp_q     <= '0;
			fill_q   <= '0;
			mcnt_q   <= '0;
			oldest_q <= '0;
			tw_q     <= '0;
		end else if (cmd.do_append) begin
			if (drop_c) begin
				if (eom_q) begin
					mcnt_q <= '0;
				end
			end else begin
				wp_q   <= wp_n;
				fill_q <= fill_n;
				tw_q   <= tw_n;
				mcnt_q <= eom_q ? '0 : mcnt_q + PTR_W'(1);
				if (ovr_c) begin
					rp_q <= rp_ovr;
				end
				if (at_full) begin
					oldest_q <= oldest_q + OFF_W'(1);
				end
			end
		end
	end

	// Input latch, read burst bookkeeping and result register.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			data_q <= data_byte;
			eom_q  <= end_of_message;
			roff_q <= read_offset;
			rlen_q <= read_length;
		end
		if (cmd.calc_dist) begin
			dist_q <= diff_c[OFF_W-1] ? '0 : diff_c;
		end
		if (cmd.calc_check) begin
			pos_q  <= pos_c;
			boff_q <= oldest_q + dist_q;
			blen_q <= len_eff;
			bcnt_q <= '0;
		end
		if (cmd.emit_byte) begin
			pos_q  <= pos_n;
			boff_q <= boff_q + OFF_W'(1);
			bcnt_q <= bcnt_q + LEN_W'(1);
		end

		if (cmd.do_append) begin
			res_byte_q   <= '0;
			res_off_q    <= tw_q;
			res_status_q <= drop_c ? orlb_pkg::ST_DROPPED : orlb_pkg::ST_STORED;
			res_last_q   <= 1'b1;
			res_fill_q   <= drop_c ? fill_q : fill_n;
			res_tw_q     <= drop_c ? tw_q : tw_n;
		end else if (cmd.emit_nodata) begin
			res_byte_q   <= '0;
			res_off_q    <= boff_q;
			res_status_q <= orlb_pkg::ST_NODATA;
			res_last_q   <= 1'b1;
			res_fill_q   <= fill_q;
			res_tw_q     <= tw_q;
		end else if (cmd.emit_byte) begin
			res_byte_q   <= rdata_q;
			res_off_q    <= boff_q;
			res_status_q <= orlb_pkg::ST_DATA;
			res_last_q   <= sts.rd_last;
			res_fill_q   <= fill_q;
			res_tw_q     <= tw_q;
		end
	end

	assign read_byte   = res_byte_q;
	assign byte_offset = res_off_q;
	assign status      = res_status_q;
	assign last        = res_last_q;
	assign fill_level  = res_fill_q;
	assign end_offset  = res_tw_q;

endmodule

// ----- hdl/overwrite_ring_log_buffer.sv -----
// ----------------------------------------------------------------------------
// overwrite_ring_log_buffer: byte log ring that overwrites its oldest bytes
// Appends bytes into a ring of 1024 * size_kib bytes, capped at MAX_RING_BYTES (holding one less),
// and serves reads by absolute offset, one result transaction per byte.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Carries
//   -------   ---------------------   ------------------------------------------
//   in        in_valid / in_ready     opcode, data_byte, end_of_message,
//                                     read_offset, read_length
//   out       out_valid / out_ready   read_byte, byte_offset, status, last,
//                                     fill_level, end_offset
//   cfg       cfg_valid / cfg_ready   size_kib
//
// An append has an accept step and then a step that writes the store and
// loads its result. A read goes through setup (accept, distance with clamp,
// range check with start address) and then an issue step and an emit step
// per returned byte, because each byte is one registered read of the store's
// read port; a read with no data ends with a no-data result step after setup.
// Reset clears all pointers at once; the byte store needs no clearing pass.
// A stalled result holds the block in its current step; the next input
// transaction is taken while the last result still waits on out_ready.
//
module overwrite_ring_log_buffer #(
	parameter int MAX_RING_BYTES = orlb_pkg::DEF_MAX_RING_BYTES,
	parameter int MAX_READ_BURST = orlb_pkg::DEF_MAX_READ_BURST,
	localparam int PTR_W = $clog2(MAX_RING_BYTES)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Item input channel.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [orlb_pkg::DATA_W-1:0]     data_byte,
	input  logic                            end_of_message,
	input  logic [orlb_pkg::OFF_W-1:0]      read_offset,
	input  logic [orlb_pkg::LEN_W-1:0]      read_length,
	// Result output channel.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [orlb_pkg::DATA_W-1:0]     read_byte,
	output logic [orlb_pkg::OFF_W-1:0]      byte_offset,
	output logic [orlb_pkg::STATUS_W-1:0]   status,
	output logic                            last,
	output logic [PTR_W-1:0]                fill_level,
	output logic [orlb_pkg::OFF_W-1:0]      end_offset,
	// Size register write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [orlb_pkg::SIZE_W-1:0]     size_kib
);

	orlb_pkg::orlb_cmd_t cmd;
	orlb_pkg::orlb_sts_t sts;

	// The controller walks each transaction through its steps; it sees the
	// datapath only through the command and status bundles.
	orlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the store, the pointers and the result register.
	orlb_dp #(
		.MAX_RING_BYTES (MAX_RING_BYTES),
		.MAX_READ_BURST (MAX_READ_BURST)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.size_kib       (size_kib),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.read_offset    (read_offset),
		.read_length    (read_length),
		.read_byte      (read_byte),
		.byte_offset    (byte_offset),
		.status         (status),
		.last           (last),
		.fill_level     (fill_level),
		.end_offset     (end_offset)
	);

`ifndef NO_ASSERTIONS
	// Every item needs at least one more step, so the block is busy right after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted on two consecutive cycles");

	// A stored byte always moves the end offset on by exactly one.
	a_store_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == orlb_pkg::ST_STORED) |->
		(end_offset == orlb_pkg::OFF_W'(byte_offset + orlb_pkg::OFF_W'(1))))
		else $error("stored byte did not advance the end offset by one");

	// Data can only come back from a ring that holds bytes.
	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == orlb_pkg::ST_DATA) |-> (fill_level != '0))
		else $error("data byte returned from an empty ring");

	// Write and no-data results are single results and must close their item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != orlb_pkg::ST_DATA) |-> last)
		else $error("single result without last");
`endif

endmodule
